// ===== design/blee_pkg.sv =====
package blee_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int CMD_W     = 4;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNTO_W    = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // microprogram counter
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_DEL_FIRST  = 4'd4,
        CMD_DEL_ALL    = 4'd5,
        CMD_SEARCH     = 4'd6,
        CMD_CLEAR      = 4'd7,
        CMD_DUMP       = 4'd8
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // datapath operations selected by the control word
    typedef enum logic [3:0] {
        ACT_ACCEPT,
        ACT_PUSH_FRONT,
        ACT_PUSH_BACK,
        ACT_POP_FRONT,
        ACT_POP_BACK,
        ACT_CHECK_EMPTY,
        ACT_FILTER,
        ACT_FILTER_END,
        ACT_SEARCH,
        ACT_CLEAR,
        ACT_DUMP
    } t_act;

    // microprogram addresses
    localparam t_pc PC_IDLE        = 4'd0;
    localparam t_pc PC_PUSH_FRONT  = 4'd1;
    localparam t_pc PC_PUSH_BACK   = 4'd2;
    localparam t_pc PC_POP_FRONT   = 4'd3;
    localparam t_pc PC_POP_BACK    = 4'd4;
    localparam t_pc PC_DELF_CHECK  = 4'd5;
    localparam t_pc PC_DELF_WALK   = 4'd6;
    localparam t_pc PC_DELF_END    = 4'd7;
    localparam t_pc PC_DELA_CHECK  = 4'd8;
    localparam t_pc PC_DELA_WALK   = 4'd9;
    localparam t_pc PC_DELA_END    = 4'd10;
    localparam t_pc PC_SRCH_CHECK  = 4'd11;
    localparam t_pc PC_SRCH_WALK   = 4'd12;
    localparam t_pc PC_CLEAR       = 4'd13;
    localparam t_pc PC_DUMP_CHECK  = 4'd14;
    localparam t_pc PC_DUMP_WALK   = 4'd15;

    typedef struct packed {
        t_act act;
        logic drop_all;
        t_pc  nxt;
    } t_uword;

    typedef struct packed {
        t_act act;
        logic drop_all;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic empty;
        logic walk_end;
        logic match;
        logic last_elem;
        logic out_free;
    } t_dp_stat;

    // control store
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            PC_PUSH_FRONT: w = '{ACT_PUSH_FRONT,  1'b0, PC_IDLE};
            PC_PUSH_BACK:  w = '{ACT_PUSH_BACK,   1'b0, PC_IDLE};
            PC_POP_FRONT:  w = '{ACT_POP_FRONT,   1'b0, PC_IDLE};
            PC_POP_BACK:   w = '{ACT_POP_BACK,    1'b0, PC_IDLE};
            PC_DELF_CHECK: w = '{ACT_CHECK_EMPTY, 1'b0, PC_DELF_WALK};
            PC_DELF_WALK:  w = '{ACT_FILTER,      1'b0, PC_DELF_END};
            PC_DELF_END:   w = '{ACT_FILTER_END,  1'b0, PC_IDLE};
            PC_DELA_CHECK: w = '{ACT_CHECK_EMPTY, 1'b1, PC_DELA_WALK};
            PC_DELA_WALK:  w = '{ACT_FILTER,      1'b1, PC_DELA_END};
            PC_DELA_END:   w = '{ACT_FILTER_END,  1'b1, PC_IDLE};
            PC_SRCH_CHECK: w = '{ACT_CHECK_EMPTY, 1'b0, PC_SRCH_WALK};
            PC_SRCH_WALK:  w = '{ACT_SEARCH,      1'b0, PC_IDLE};
            PC_CLEAR:      w = '{ACT_CLEAR,       1'b0, PC_IDLE};
            PC_DUMP_CHECK: w = '{ACT_CHECK_EMPTY, 1'b0, PC_DUMP_WALK};
            PC_DUMP_WALK:  w = '{ACT_DUMP,        1'b0, PC_IDLE};
            default:       w = '{ACT_ACCEPT,      1'b0, PC_IDLE};
        endcase
        return w;
    endfunction

    // entry point of each command's routine
    function automatic t_pc dispatch(logic [CMD_W-1:0] cmd);
        t_pc pc;
        case (t_cmd'(cmd))
            CMD_PUSH_FRONT: pc = PC_PUSH_FRONT;
            CMD_PUSH_BACK:  pc = PC_PUSH_BACK;
            CMD_POP_FRONT:  pc = PC_POP_FRONT;
            CMD_POP_BACK:   pc = PC_POP_BACK;
            CMD_DEL_FIRST:  pc = PC_DELF_CHECK;
            CMD_DEL_ALL:    pc = PC_DELA_CHECK;
            CMD_SEARCH:     pc = PC_SRCH_CHECK;
            CMD_CLEAR:      pc = PC_CLEAR;
            CMD_DUMP:       pc = PC_DUMP_CHECK;
            default:        pc = PC_IDLE;
        endcase
        return pc;
    endfunction

endpackage

// ===== design/blee_seq.sv =====
module blee_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [blee_pkg::CMD_W-1:0] i_cmd,
    input  blee_pkg::t_dp_stat         i_stat,
    output blee_pkg::t_ctrl            o_ctrl,
    output logic                       o_in_ready
);

    blee_pkg::t_pc    r_pc;
    blee_pkg::t_pc    n_pc;
    blee_pkg::t_uword uw;
    logic             fire;

    // control word fetch
    assign uw = blee_pkg::ucode(r_pc);

    // step may proceed once its beat can be taken; filter steps always proceed
    always_comb begin
        case (uw.act)
            blee_pkg::ACT_ACCEPT: fire = i_in_valid;
            blee_pkg::ACT_FILTER: fire = 1'b1;
            default:              fire = i_stat.out_free;
        endcase
    end

    assign o_in_ready      = (uw.act == blee_pkg::ACT_ACCEPT);
    assign o_ctrl.act      = uw.act;
    assign o_ctrl.drop_all = uw.drop_all;
    assign o_ctrl.fire     = fire;

    // next step: hold, loop, jump or dispatch
    always_comb begin
        n_pc = r_pc;
        if (fire) begin
            case (uw.act)
                blee_pkg::ACT_ACCEPT: begin
                    n_pc = blee_pkg::dispatch(i_cmd);
                end
                blee_pkg::ACT_CHECK_EMPTY: begin
                    n_pc = i_stat.empty ? blee_pkg::PC_IDLE : uw.nxt;
                end
                blee_pkg::ACT_FILTER: begin
                    if (i_stat.walk_end) n_pc = uw.nxt;
                end
                blee_pkg::ACT_SEARCH: begin
                    if (i_stat.walk_end || i_stat.match) n_pc = uw.nxt;
                end
                blee_pkg::ACT_DUMP: begin
                    if (i_stat.last_elem) n_pc = uw.nxt;
                end
                default: begin
                    n_pc = uw.nxt;
                end
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= blee_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== design/blee_dp.sv =====
module blee_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blee_pkg::t_ctrl             i_ctrl,
    input  logic [blee_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_out_ready,
    output blee_pkg::t_dp_stat          o_stat,
    output logic                        o_out_valid,
    output blee_pkg::t_status           o_status,
    output logic                        o_found,
    output logic [blee_pkg::VAL_W-1:0]  o_element,
    output logic [blee_pkg::CNT_W-1:0]  o_removed,
    output logic [blee_pkg::CNT_W-1:0]  o_occupancy,
    output logic                        o_last
);

    localparam int IW = blee_pkg::IDX_W;
    localparam int CW = blee_pkg::CNT_W;
    localparam int DW = blee_pkg::VAL_W;

    // element store as a ring, head marks the front
    logic [DW-1:0] r_store [blee_pkg::CAPACITY];
    logic [IW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;

    // per-command working registers
    logic [DW-1:0] r_val,   n_val;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_j,     n_j;
    logic [CW-1:0] r_n,     n_n;
    logic          r_found, n_found;

    // result register
    logic              r_out_valid;
    blee_pkg::t_status r_status,  n_status;
    logic              r_ofound,  n_ofound;
    logic [DW-1:0]     r_elem,    n_elem;
    logic [CW-1:0]     r_removed, n_removed;
    logic [CW-1:0]     r_occ,     n_occ;
    logic              r_last,    n_last;
    logic              emit;

    // store write port
    logic          we;
    logic [IW-1:0] waddr;
    logic [DW-1:0] wdata;

    logic [CW-1:0] rd_off;
    logic [IW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic          empty;
    logic          full;
    logic          walk_end;
    logic          match;
    logic          last_elem;
    logic          out_free;
    logic          drop;

    // ring position of an offset from the head
    function automatic logic [IW-1:0] ring_pos(logic [IW-1:0] base, logic [CW-1:0] off);
        logic [IW+1:0] sum;
        sum = (IW+2)'(base) + (IW+2)'(off);
        if (sum >= (IW+2)'(blee_pkg::CAPACITY)) begin
            sum = sum - (IW+2)'(blee_pkg::CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    // status towards the sequencer
    assign empty     = (r_count == '0);
    assign full      = (r_count == CW'(blee_pkg::CAPACITY));
    assign walk_end  = (r_i == r_count);
    assign last_elem = (r_i == r_count - CW'(1));
    assign out_free  = !r_out_valid || i_out_ready;

    // single read port
    always_comb begin
        case (i_ctrl.act)
            blee_pkg::ACT_POP_FRONT: rd_off = '0;
            blee_pkg::ACT_POP_BACK:  rd_off = r_count - CW'(1);
            default:                 rd_off = r_i;
        endcase
    end
    assign raddr = ring_pos(r_head, rd_off);
    assign rdata = r_store[raddr];
    assign match = (rdata == r_val);

    assign head_dec = (r_head == '0) ? IW'(blee_pkg::CAPACITY - 1) : r_head - IW'(1);
    assign head_inc = ring_pos(r_head, CW'(1));
    assign drop     = match && (i_ctrl.drop_all || !r_found);

    assign o_stat.empty     = empty;
    assign o_stat.walk_end  = walk_end;
    assign o_stat.match     = match;
    assign o_stat.last_elem = last_elem;
    assign o_stat.out_free  = out_free;

    // operation of the current control word
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_val     = r_val;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_found   = r_found;
        emit      = 1'b0;
        n_status  = blee_pkg::ST_OK;
        n_ofound  = 1'b0;
        n_elem    = '0;
        n_removed = '0;
        n_occ     = r_count;
        n_last    = 1'b1;
        we        = 1'b0;
        waddr     = ring_pos(r_head, r_count);
        wdata     = r_val;
        if (i_ctrl.fire) begin
            case (i_ctrl.act)
                blee_pkg::ACT_ACCEPT: begin
                    n_val   = i_value;
                    n_i     = '0;
                    n_j     = '0;
                    n_n     = '0;
                    n_found = 1'b0;
                end
                blee_pkg::ACT_PUSH_FRONT, blee_pkg::ACT_PUSH_BACK: begin
                    emit = 1'b1;
                    if (full) begin
                        n_status = blee_pkg::ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        n_occ   = r_count + CW'(1);
                        if (i_ctrl.act == blee_pkg::ACT_PUSH_FRONT) begin
                            waddr  = head_dec;
                            n_head = head_dec;
                        end
                    end
                end
                blee_pkg::ACT_POP_FRONT, blee_pkg::ACT_POP_BACK: begin
                    emit = 1'b1;
                    if (empty) begin
                        n_status = blee_pkg::ST_EMPTY;
                    end else begin
                        n_elem    = rdata;
                        n_removed = CW'(1);
                        n_count   = r_count - CW'(1);
                        n_occ     = r_count - CW'(1);
                        if (i_ctrl.act == blee_pkg::ACT_POP_FRONT) begin
                            n_head = head_inc;
                        end
                    end
                end
                blee_pkg::ACT_CHECK_EMPTY: begin
                    if (empty) begin
                        emit     = 1'b1;
                        n_status = blee_pkg::ST_EMPTY;
                    end
                end
                blee_pkg::ACT_FILTER: begin
                    // compact survivors towards the front
                    if (!walk_end) begin
                        n_i = r_i + CW'(1);
                        if (drop) begin
                            n_n     = r_n + CW'(1);
                            n_found = 1'b1;
                        end else begin
                            we    = 1'b1;
                            waddr = ring_pos(r_head, r_j);
                            wdata = rdata;
                            n_j   = r_j + CW'(1);
                        end
                    end
                end
                blee_pkg::ACT_FILTER_END: begin
                    emit    = 1'b1;
                    n_count = r_j;
                    n_occ   = r_j;
                    if (r_n == '0) begin
                        n_status = blee_pkg::ST_NOT_FOUND;
                    end else begin
                        n_ofound  = 1'b1;
                        n_elem    = r_val;
                        n_removed = r_n;
                    end
                end
                blee_pkg::ACT_SEARCH: begin
                    if (walk_end) begin
                        emit     = 1'b1;
                        n_status = blee_pkg::ST_NOT_FOUND;
                    end else if (match) begin
                        emit     = 1'b1;
                        n_ofound = 1'b1;
                        n_elem   = r_val;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
                blee_pkg::ACT_CLEAR: begin
                    emit = 1'b1;
                    if (empty) begin
                        n_status = blee_pkg::ST_EMPTY;
                    end else begin
                        n_removed = r_count;
                        n_count   = '0;
                        n_occ     = '0;
                    end
                end
                blee_pkg::ACT_DUMP: begin
                    emit   = 1'b1;
                    n_elem = rdata;
                    n_last = last_elem;
                    n_i    = r_i + CW'(1);
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_i     <= n_i;
        r_j     <= n_j;
        r_n     <= n_n;
        r_found <= n_found;
        if (emit) begin
            r_status  <= n_status;
            r_ofound  <= n_ofound;
            r_elem    <= n_elem;
            r_removed <= n_removed;
            r_occ     <= n_occ;
            r_last    <= n_last;
        end
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_ofound;
    assign o_element   = r_elem;
    assign o_removed   = r_removed;
    assign o_occupancy = r_occ;
    assign o_last      = r_last;

endmodule

// ===== design/bounded_list_engine_unit.sv =====
// Ordered list of up to 16 signed 32-bit values, front at position 0, driven by
// command beats on the slave stream: push front/back, pop front/back, delete
// first match, delete all matches, search, clear and dump. Every valid command
// yields one result beat with tlast set; dump yields one beat per element,
// front to back, tlast on the final one; codes 9 to 15 are taken and dropped.
// Commands are handled one at a time by a microprogram sequencer over a ring
// buffer with one read port. Search, the deletes and dump walk the list one
// stored element per cycle, the search and dump walks only while the result
// register is free. A stalled result beat holds every step that may produce a
// beat until the sink takes it.
module bounded_list_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // command[3:0], value[35:4], zero pad[39:36]
    input  logic [blee_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[1:0], found[2], element[34:3], removed_count[41:35],
    // occupancy[48:42], zero pad[55:49]
    output logic [blee_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    blee_pkg::t_ctrl                 ctrl;
    blee_pkg::t_dp_stat              stat;
    blee_pkg::t_status               status;
    logic                            found;
    logic [blee_pkg::VAL_W-1:0]      element;
    logic [blee_pkg::CNT_W-1:0]      removed;
    logic [blee_pkg::CNT_W-1:0]      occupancy;

    // microprogram sequencer
    blee_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_cmd      (i_s_axis_tdata[blee_pkg::CMD_W-1:0]),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (o_s_axis_tready)
    );

    // list datapath and result register
    blee_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_value     (i_s_axis_tdata[blee_pkg::CMD_W +: blee_pkg::VAL_W]),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (status),
        .o_found     (found),
        .o_element   (element),
        .o_removed   (removed),
        .o_occupancy (occupancy),
        .o_last      (o_m_axis_tlast)
    );

    // result beat packing
    assign o_m_axis_tdata = {
        7'd0,
        blee_pkg::CNTO_W'(occupancy),
        blee_pkg::CNTO_W'(removed),
        element,
        found,
        status
    };

endmodule

// ===== verif/bounded_list_engine_unit_tb.sv =====
module bounded_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one command beat as it sits in the stimulus queue
    typedef struct packed {
        logic [blee_pkg::CMD_W-1:0] cmd;
        logic [blee_pkg::VAL_W-1:0] value;
    } t_cmd_beat;

    // one result beat as the list should report it
    typedef struct packed {
        blee_pkg::t_status           status;
        logic                        found;
        logic [blee_pkg::VAL_W-1:0]  element;
        logic [blee_pkg::CNTO_W-1:0] removed;
        logic [blee_pkg::CNTO_W-1:0] occupancy;
        logic                        last;
    } t_list_result;

    // command mix for random runs, pushes weighted up to keep the list busy
    localparam blee_pkg::t_cmd OP_MIX [12] = '{
        blee_pkg::CMD_PUSH_FRONT, blee_pkg::CMD_PUSH_BACK, blee_pkg::CMD_PUSH_FRONT,
        blee_pkg::CMD_PUSH_BACK, blee_pkg::CMD_PUSH_BACK, blee_pkg::CMD_POP_FRONT,
        blee_pkg::CMD_POP_BACK, blee_pkg::CMD_DEL_FIRST, blee_pkg::CMD_DEL_ALL,
        blee_pkg::CMD_SEARCH, blee_pkg::CMD_CLEAR, blee_pkg::CMD_DUMP
    };

    localparam int RANDOM_TARGET = 100;
    localparam int HOLD_TRIGGER  = 45;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic [blee_pkg::S_TDATA_W-1:0]   s_data = '0;
    logic                             s_ready;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [blee_pkg::M_TDATA_W-1:0]   m_data;
    logic                             m_last;

    t_cmd_beat                  command_queue[$];
    t_list_result               pending_results[$];
    logic [blee_pkg::VAL_W-1:0] list_contents[$];
    logic [blee_pkg::VAL_W-1:0] value_pool[8];

    t_cmd_beat      cur_beat = '0;
    t_list_result   want;
    logic           next_valid;
    logic           rdy_next;
    logic           hold_done = 1'b0;
    int             hold_left = 0;
    int             burst_left = 4;
    int             gap_left = 0;
    int             accepted_count = 0;
    int             queued_items = 0;
    int             fail_count = 0;
    int             runs;
    int             pick;
    logic [7:0]     rx_cycle = '0;

    bounded_list_engine_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always #1 i_clk = ~i_clk;

    // list behaviour: update the shadow list and queue the beats it should yield
    function automatic void apply_command(input logic [blee_pkg::CMD_W-1:0] cmd,
                                          input logic [blee_pkg::VAL_W-1:0] val);
        t_list_result               r;
        logic [blee_pkg::VAL_W-1:0] kept[$];
        int                         hit;
        r = '0;
        r.status = blee_pkg::ST_OK;
        r.last = 1'b1;
        // unused codes are swallowed without a result
        if (cmd > blee_pkg::CMD_DUMP)
            return;
        case (cmd)
            blee_pkg::CMD_PUSH_FRONT, blee_pkg::CMD_PUSH_BACK: begin
                if (list_contents.size() >= blee_pkg::CAPACITY)
                    r.status = blee_pkg::ST_FULL;
                else if (cmd == blee_pkg::CMD_PUSH_FRONT)
                    list_contents.push_front(val);
                else
                    list_contents.push_back(val);
            end
            blee_pkg::CMD_POP_FRONT, blee_pkg::CMD_POP_BACK: begin
                if (list_contents.size() == 0) begin
                    r.status = blee_pkg::ST_EMPTY;
                end else begin
                    if (cmd == blee_pkg::CMD_POP_FRONT)
                        r.element = list_contents.pop_front();
                    else
                        r.element = list_contents.pop_back();
                    r.removed = blee_pkg::CNTO_W'(1);
                end
            end
            blee_pkg::CMD_DEL_FIRST, blee_pkg::CMD_SEARCH: begin
                // match nearest the front wins
                hit = -1;
                for (int i = list_contents.size() - 1; i >= 0; i--)
                    if (list_contents[i] == val)
                        hit = i;
                if (list_contents.size() == 0) begin
                    r.status = blee_pkg::ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = blee_pkg::ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    r.element = val;
                    if (cmd == blee_pkg::CMD_DEL_FIRST) begin
                        list_contents.delete(hit);
                        r.removed = blee_pkg::CNTO_W'(1);
                    end
                end
            end
            blee_pkg::CMD_DEL_ALL: begin
                if (list_contents.size() == 0) begin
                    r.status = blee_pkg::ST_EMPTY;
                end else begin
                    foreach (list_contents[i])
                        if (list_contents[i] != val)
                            kept.push_back(list_contents[i]);
                    r.removed = blee_pkg::CNTO_W'(list_contents.size() - kept.size());
                    list_contents = kept;
                    if (r.removed == 0) begin
                        r.status = blee_pkg::ST_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        r.element = val;
                    end
                end
            end
            blee_pkg::CMD_CLEAR: begin
                if (list_contents.size() == 0) begin
                    r.status = blee_pkg::ST_EMPTY;
                end else begin
                    r.removed = blee_pkg::CNTO_W'(list_contents.size());
                    list_contents.delete();
                end
            end
            blee_pkg::CMD_DUMP: begin
                // one beat per element, front first, last flag on the final one
                if (list_contents.size() == 0) begin
                    r.status = blee_pkg::ST_EMPTY;
                end else begin
                    foreach (list_contents[i]) begin
                        r.element = list_contents[i];
                        r.last = (i == list_contents.size() - 1);
                        r.occupancy = blee_pkg::CNTO_W'(list_contents.size());
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.occupancy = blee_pkg::CNTO_W'(list_contents.size());
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(input string name,
                                        input logic [blee_pkg::VAL_W-1:0] exp_v,
                                        input logic [blee_pkg::VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic void add_cmd(input logic [blee_pkg::CMD_W-1:0] cmd,
                                    input logic [blee_pkg::VAL_W-1:0] v);
        t_cmd_beat b;
        b.cmd = cmd;
        b.value = v;
        command_queue.push_back(b);
        if (cmd <= blee_pkg::CMD_DUMP)
            queued_items++;
    endfunction

    // mostly values from a small pool so that searches and deletes hit
    function automatic logic [blee_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    // command sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        next_valid = s_valid;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                apply_command(cur_beat.cmd, cur_beat.value);
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (command_queue.size() > 0) begin
                    cur_beat = command_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        // long stretch with no idling
                        burst_left = $urandom_range(20, 40);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = $urandom_range(0, 6);
                    end
                end
            end
        end
        s_valid <= next_valid;
        s_data <= {{(blee_pkg::S_TDATA_W - blee_pkg::CMD_W - blee_pkg::VAL_W){1'b0}},
                   cur_beat.value, cur_beat.cmd};
    end

    // result sink: stall pattern cycling through four modes, plus one long hold-off
    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 8'd1;
        if (!hold_done && accepted_count >= HOLD_TRIGGER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: rdy_next = 1'b1;
                2'd1: rdy_next = 1'($urandom_range(0, 1));
                2'd2: rdy_next = (rx_cycle % 3) != 0;
                default: rdy_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_ready <= rdy_next;
    end

    // result checker against the oldest expected beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", blee_pkg::VAL_W'(want.status),
                            blee_pkg::VAL_W'(m_data[1:0]));
                check_field("found", blee_pkg::VAL_W'(want.found),
                            blee_pkg::VAL_W'(m_data[2]));
                check_field("element", want.element, m_data[34:3]);
                check_field("removed_count", blee_pkg::VAL_W'(want.removed),
                            blee_pkg::VAL_W'(m_data[41:35]));
                check_field("occupancy", blee_pkg::VAL_W'(want.occupancy),
                            blee_pkg::VAL_W'(m_data[48:42]));
                check_field("last", blee_pkg::VAL_W'(want.last), blee_pkg::VAL_W'(m_last));
            end
        end
    end

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 8; i++)
            value_pool[i] = $urandom;

        // every non-push command on an empty list
        add_cmd(blee_pkg::CMD_POP_FRONT, 32'h0);
        add_cmd(blee_pkg::CMD_POP_BACK, 32'h0);
        add_cmd(blee_pkg::CMD_DEL_FIRST, 32'h0);
        add_cmd(blee_pkg::CMD_DEL_ALL, 32'h0);
        add_cmd(blee_pkg::CMD_SEARCH, 32'h0);
        add_cmd(blee_pkg::CMD_CLEAR, 32'h0);
        add_cmd(blee_pkg::CMD_DUMP, 32'h0);
        // extremes at both ends, with a repeated value
        add_cmd(blee_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
        add_cmd(blee_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        add_cmd(blee_pkg::CMD_PUSH_BACK, 32'h0000_0000);
        add_cmd(blee_pkg::CMD_PUSH_BACK, 32'h8000_0000);
        add_cmd(blee_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        add_cmd(blee_pkg::CMD_SEARCH, 32'h8000_0000);
        add_cmd(blee_pkg::CMD_SEARCH, 32'h0000_0005);
        // front match goes, back copy stays
        add_cmd(blee_pkg::CMD_DEL_FIRST, 32'h8000_0000);
        add_cmd(blee_pkg::CMD_DUMP, 32'h0);
        add_cmd(blee_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
        add_cmd(blee_pkg::CMD_DEL_ALL, 32'h7FFF_FFFF);
        add_cmd(blee_pkg::CMD_DEL_FIRST, 32'h0000_3039);
        add_cmd(blee_pkg::CMD_DEL_ALL, 32'h0000_0309);
        // unused codes, lowest and highest
        add_cmd(4'd9, 32'hFFFF_FFFF);
        add_cmd(4'd15, 32'hFFFF_FFFF);
        add_cmd(blee_pkg::CMD_POP_FRONT, 32'h0);
        add_cmd(blee_pkg::CMD_POP_BACK, 32'h0);
        add_cmd(blee_pkg::CMD_CLEAR, 32'h0);

        while (queued_items < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // fill past capacity so inserts bounce, then dump
                    runs = $urandom_range(17, 19);
                    repeat (runs)
                        add_cmd($urandom_range(0, 1) ? blee_pkg::CMD_PUSH_BACK
                                                     : blee_pkg::CMD_PUSH_FRONT,
                                pick_value());
                    add_cmd(blee_pkg::CMD_DUMP, pick_value());
                    if ($urandom_range(0, 1))
                        add_cmd(blee_pkg::CMD_CLEAR, pick_value());
                end
                8, 9: begin
                    // raw noise over every command code and value bit
                    runs = $urandom_range(2, 4);
                    repeat (runs)
                        add_cmd(4'($urandom_range(0, 15)), $urandom);
                end
                default: begin
                    runs = $urandom_range(4, 10);
                    repeat (runs) begin
                        pick = $urandom_range(0, 11);
                        add_cmd(OP_MIX[pick], pick_value());
                    end
                end
            endcase
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (command_queue.size() != 0 || s_valid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #400_000;
        $display("tb: failure");
        $finish;
    end

endmodule
